@@ design/ps2a_pkg.sv @@
// ============================================================================
// PS/2 scancode translator package
// Shared types, key codes and character tables for the set-1 to ASCII block.
// ============================================================================
package ps2a_pkg;

    localparam int TABLE_LEN = 58;
    localparam int MAX_CHARS = 4;
    localparam int CHAR_W    = 7;
    localparam int CODE_W    = 8;
    localparam int KEY_W     = 7;
    localparam int COUNT_W   = $clog2(MAX_CHARS + 1);
    localparam int POS_W     = $clog2(MAX_CHARS);

    // Prefix code, release bit, and key codes with the release bit removed.
    localparam logic [CODE_W-1:0] PREFIX_CODE = 8'hE0;
    localparam int                BREAK_BIT   = 7;

    localparam logic [KEY_W-1:0] KEY_ESC     = 7'h01;
    localparam logic [KEY_W-1:0] KEY_BKSP    = 7'h0E;
    localparam logic [KEY_W-1:0] KEY_TAB     = 7'h0F;
    localparam logic [KEY_W-1:0] KEY_RETURN  = 7'h1C;
    localparam logic [KEY_W-1:0] KEY_CTRL_L  = 7'h1D;
    localparam logic [KEY_W-1:0] KEY_SHIFT_L = 7'h2A;
    localparam logic [KEY_W-1:0] KEY_SHIFT_R = 7'h36;
    localparam logic [KEY_W-1:0] KEY_CAPS    = 7'h3A;
    localparam logic [KEY_W-1:0] KEY_HOME    = 7'h47;
    localparam logic [KEY_W-1:0] KEY_UP      = 7'h48;
    localparam logic [KEY_W-1:0] KEY_LEFT    = 7'h4B;
    localparam logic [KEY_W-1:0] KEY_RIGHT   = 7'h4D;
    localparam logic [KEY_W-1:0] KEY_END     = 7'h4F;
    localparam logic [KEY_W-1:0] KEY_DOWN    = 7'h50;
    localparam logic [KEY_W-1:0] KEY_DEL     = 7'h53;

    localparam logic [CHAR_W-1:0] CH_ESC   = 7'h1B;
    localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_HT    = 7'h09;
    localparam logic [CHAR_W-1:0] CH_LBRK  = 7'h5B;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_B     = 7'h42;
    localparam logic [CHAR_W-1:0] CH_C     = 7'h43;
    localparam logic [CHAR_W-1:0] CH_D     = 7'h44;
    localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
    localparam logic [CHAR_W-1:0] CH_H     = 7'h48;
    localparam logic [CHAR_W-1:0] CH_3     = 7'h33;
    localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 7'h7A;

    localparam logic [CHAR_W-1:0] LOW_TAB [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] UP_TAB [TABLE_LEN] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [COUNT_W-1:0]               count;
    } seq_t;

endpackage

@@ design/ps2_scancode_to_ascii.sv @@
// ============================================================================
// PS/2 set-1 scancode to ASCII translator
// Turns raw scancode bytes into ASCII characters and cursor escape sequences.
// ============================================================================
// Each slave beat carries one raw set-1 scancode byte. Each master beat
// carries one ASCII character; tlast marks the final character that a
// scancode causes. Prefix bytes, releases, modifier keys and keys with no
// character cause no master beat at all.
// A scancode is registered in the input register, decoded against the
// shift, ctrl, caps lock and prefix flags, and loaded into the emitter,
// whose register offers the first character on the master side.
// The emitter sends one character per cycle while the receiver is ready.
// A scancode that gives no character leaves the input register without
// waiting for the emitter. A new scancode is taken every cycle while the
// emitter keeps pace.
// Reset clears all flags and empties both the input register and the
// emitter. When the receiver stalls, the emitter holds its character; a scancode
// with characters then waits in the input register and s_axis_tready drops.
// ============================================================================
module ps2_scancode_to_ascii
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] scancode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] char_code, [7] zero fill
    output logic       m_axis_tlast    // last_char
);

    logic                        in_valid_reg;
    logic [ps2a_pkg::CODE_W-1:0] in_code_reg;
    logic                        advance;
    logic                        emit_free;
    ps2a_pkg::seq_t              seq;
    logic [ps2a_pkg::CHAR_W-1:0] char_code;

    assign advance       = in_valid_reg && ((seq.count == '0) || emit_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tdata  = {1'b0, char_code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_code_reg <= s_axis_tdata;
        end
    end

    ps2a_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .code    (in_code_reg),
        .advance (advance),
        .seq     (seq)
    );

    ps2a_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .seq       (seq),
        .free      (emit_free),
        .tvalid    (m_axis_tvalid),
        .tready    (m_axis_tready),
        .char_code (char_code),
        .last_char (m_axis_tlast)
    );

endmodule

@@ design/ps2a_decode.sv @@
// ============================================================================
// Scancode decoder
// Holds the modifier and prefix flags and turns one scancode into a
// sequence of zero to four characters.
// ============================================================================
module ps2a_decode
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ps2a_pkg::CODE_W-1:0] code,
    input  logic                        advance,
    output ps2a_pkg::seq_t              seq
);

    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic caps_reg, caps_next;
    logic prefix_reg, prefix_next;

    logic [ps2a_pkg::KEY_W-1:0]  key;
    logic                        in_table;
    logic [5:0]                  tab_idx;
    logic [ps2a_pkg::CHAR_W-1:0] low_char;
    logic [ps2a_pkg::CHAR_W-1:0] up_char;
    logic [ps2a_pkg::CHAR_W-1:0] tab_char;
    logic                        letter;
    logic                        upper_sel;

    assign key      = code[ps2a_pkg::KEY_W-1:0];
    assign in_table = (code < 8'(ps2a_pkg::TABLE_LEN));
    assign tab_idx  = code[5:0];

    always_comb
    begin
        low_char = '0;
        up_char  = '0;
        if (in_table)
        begin
            low_char = ps2a_pkg::LOW_TAB[tab_idx];
            up_char  = ps2a_pkg::UP_TAB[tab_idx];
        end
    end

    assign letter    = (low_char >= ps2a_pkg::CH_LOW_A) && (low_char <= ps2a_pkg::CH_LOW_Z);
    assign upper_sel = shift_reg ^ (caps_reg & letter);
    assign tab_char  = upper_sel ? up_char : low_char;

    always_comb
    begin
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        seq         = '0;

        if (code == ps2a_pkg::PREFIX_CODE)
        begin
            prefix_next = 1'b1;
        end
        else if (prefix_reg)
        begin
            prefix_next = 1'b0;
            if (!code[ps2a_pkg::BREAK_BIT])
            begin
                seq.chars[0] = ps2a_pkg::CH_ESC;
                seq.chars[1] = ps2a_pkg::CH_LBRK;
                unique case (key)
                    ps2a_pkg::KEY_UP:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_A;
                        seq.count    = 3'd3;
                    end
                    ps2a_pkg::KEY_DOWN:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_B;
                        seq.count    = 3'd3;
                    end
                    ps2a_pkg::KEY_RIGHT:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_C;
                        seq.count    = 3'd3;
                    end
                    ps2a_pkg::KEY_LEFT:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_D;
                        seq.count    = 3'd3;
                    end
                    ps2a_pkg::KEY_HOME:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_H;
                        seq.count    = 3'd3;
                    end
                    ps2a_pkg::KEY_END:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_F;
                        seq.count    = 3'd3;
                    end
                    ps2a_pkg::KEY_DEL:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_3;
                        seq.chars[3] = ps2a_pkg::CH_TILDE;
                        seq.count    = 3'd4;
                    end
                    default:
                    begin
                        seq.count = '0;
                    end
                endcase
            end
        end
        else if (code[ps2a_pkg::BREAK_BIT])
        begin
            unique case (key) inside
                ps2a_pkg::KEY_SHIFT_L, ps2a_pkg::KEY_SHIFT_R: shift_next = 1'b0;
                ps2a_pkg::KEY_CTRL_L:                         ctrl_next  = 1'b0;
                default:                                      ;
            endcase
        end
        else
        begin
            unique case (key) inside
                ps2a_pkg::KEY_SHIFT_L, ps2a_pkg::KEY_SHIFT_R: shift_next = 1'b1;
                ps2a_pkg::KEY_CTRL_L:                         ctrl_next  = 1'b1;
                ps2a_pkg::KEY_CAPS:                           caps_next  = !caps_reg;
                ps2a_pkg::KEY_ESC:
                begin
                    seq.chars[0] = ps2a_pkg::CH_ESC;
                    seq.count    = 3'd1;
                end
                ps2a_pkg::KEY_BKSP:
                begin
                    seq.chars[0] = ps2a_pkg::CH_BS;
                    seq.count    = 3'd1;
                end
                ps2a_pkg::KEY_RETURN:
                begin
                    seq.chars[0] = ps2a_pkg::CH_LF;
                    seq.count    = 3'd1;
                end
                ps2a_pkg::KEY_TAB:
                begin
                    seq.chars[0] = ps2a_pkg::CH_HT;
                    seq.count    = 3'd1;
                end
                default:
                begin
                    if (tab_char != '0)
                    begin
                        if (!ctrl_reg)
                        begin
                            seq.chars[0] = tab_char;
                            seq.count    = 3'd1;
                        end
                        else if (letter)
                        begin
                            // A letter's low five bits are its place in the alphabet.
                            seq.chars[0] = {2'b00, tab_char[4:0]};
                            seq.count    = 3'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else if (advance)
        begin
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

@@ design/ps2a_emit.sv @@
// ============================================================================
// Character emitter
// Holds one decoded sequence and sends one beat per cycle while tready is high.
// ============================================================================
module ps2a_emit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  ps2a_pkg::seq_t              seq,
    output logic                        free,
    output logic                        tvalid,
    input  logic                        tready,
    output logic [ps2a_pkg::CHAR_W-1:0] char_code,
    output logic                        last_char
);

    logic [ps2a_pkg::MAX_CHARS-1:0][ps2a_pkg::CHAR_W-1:0] chars_reg;
    logic [ps2a_pkg::COUNT_W-1:0]                         len_reg;
    logic [ps2a_pkg::POS_W-1:0]                           pos_reg;
    logic                                                 valid_reg;
    logic                                                 take;

    assign tvalid    = valid_reg;
    assign char_code = chars_reg[pos_reg];
    assign last_char = ((ps2a_pkg::COUNT_W'(pos_reg) + 1'b1) == len_reg);
    assign free      = !valid_reg || (tready && last_char);
    assign take      = load && free && (seq.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end
        else if (valid_reg && tready)
        begin
            if (last_char)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chars_reg <= seq.chars;
            len_reg   <= seq.count;
        end
    end

endmodule

@@ tb/ps2_scancode_to_ascii_tb.sv @@
// ============================================================================
// PS/2 scancode translator testbench
// Drives raw set-1 scancode bytes into the translator and checks every ASCII
// beat against an internal model of the modifier flags and key tables. A
// short directed table covers the extremes, modifiers and cursor keys, then
// random keystroke sequences run under three patterns of idling on the two
// stream interfaces.
// ============================================================================
module ps2_scancode_to_ascii_tb;

    typedef struct packed {
        logic [2:0]                       count;
        logic [0:3][ps2a_pkg::CHAR_W-1:0] chars;
    } char_seq_t;

    typedef struct packed {
        logic [ps2a_pkg::CHAR_W-1:0] char_code;
        logic                        last_char;
    } char_beat_t;

    typedef struct packed {
        logic [ps2a_pkg::CODE_W-1:0]      code;
        logic                             typed;
        logic [2:0]                       count;
        logic [0:3][ps2a_pkg::CHAR_W-1:0] chars;
    } stim_row_t;

    localparam logic [ps2a_pkg::CODE_W-1:0]   SC_A        = 8'h1E;
    localparam logic [ps2a_pkg::CODE_W-1:0]   SC_C        = 8'h2E;
    localparam logic [ps2a_pkg::CODE_W-1:0]   SC_1        = 8'h02;
    localparam logic [ps2a_pkg::CODE_W-1:0]   SC_MAX      = 8'h7F;
    localparam logic [ps2a_pkg::CODE_W-1:0]   SC_ALL      = 8'hFF;
    localparam logic [4*ps2a_pkg::CHAR_W-1:0] NO_CHARS    = '0;
    localparam int                            N_ROWS      = 26;
    localparam int                            PHASE_ITEMS = 85;

    localparam logic [ps2a_pkg::CHAR_W-1:0] LOWER_KEYS [ps2a_pkg::TABLE_LEN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [ps2a_pkg::CHAR_W-1:0] UPPER_KEYS [ps2a_pkg::TABLE_LEN] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [ps2a_pkg::KEY_W-1:0] CURSOR_KEYS [7] = '{
        ps2a_pkg::KEY_UP, ps2a_pkg::KEY_DOWN, ps2a_pkg::KEY_RIGHT, ps2a_pkg::KEY_LEFT,
        ps2a_pkg::KEY_HOME, ps2a_pkg::KEY_END, ps2a_pkg::KEY_DEL
    };

    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{8'h00,                          1'b1, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_ESC},      1'b1, 3'd1, {ps2a_pkg::CH_ESC, 21'h0}},
        '{SC_A,                           1'b1, 3'd1, {ps2a_pkg::CH_LOW_A, 21'h0}},
        '{SC_MAX,                         1'b1, 3'd0, NO_CHARS},
        '{SC_ALL,                         1'b1, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_SHIFT_L},  1'b0, 3'd0, NO_CHARS},
        '{SC_A,                           1'b0, 3'd0, NO_CHARS},
        '{SC_1,                           1'b0, 3'd0, NO_CHARS},
        '{{1'b1, ps2a_pkg::KEY_SHIFT_L},  1'b0, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_CAPS},     1'b0, 3'd0, NO_CHARS},
        '{SC_A,                           1'b0, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_SHIFT_R},  1'b0, 3'd0, NO_CHARS},
        '{SC_A,                           1'b0, 3'd0, NO_CHARS},
        '{{1'b1, ps2a_pkg::KEY_SHIFT_R},  1'b0, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_CAPS},     1'b0, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_CTRL_L},   1'b0, 3'd0, NO_CHARS},
        '{SC_C,                           1'b0, 3'd0, NO_CHARS},
        '{SC_1,                           1'b0, 3'd0, NO_CHARS},
        '{{1'b1, ps2a_pkg::KEY_CTRL_L},   1'b0, 3'd0, NO_CHARS},
        '{ps2a_pkg::PREFIX_CODE,          1'b0, 3'd0, NO_CHARS},
        '{ps2a_pkg::PREFIX_CODE,          1'b1, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_UP},       1'b1, 3'd3,
          {ps2a_pkg::CH_ESC, ps2a_pkg::CH_LBRK, ps2a_pkg::CH_A, 7'h00}},
        '{ps2a_pkg::PREFIX_CODE,          1'b0, 3'd0, NO_CHARS},
        '{{1'b0, ps2a_pkg::KEY_DEL},      1'b1, 3'd4,
          {ps2a_pkg::CH_ESC, ps2a_pkg::CH_LBRK, ps2a_pkg::CH_3, ps2a_pkg::CH_TILDE}},
        '{ps2a_pkg::PREFIX_CODE,          1'b0, 3'd0, NO_CHARS},
        '{{1'b1, ps2a_pkg::KEY_UP},       1'b1, 3'd0, NO_CHARS}
    };

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    logic shift_on;
    logic ctrl_on;
    logic caps_on;
    logic ext_pending;

    char_beat_t char_q [$];
    int         src_idle_pct = 0;
    int         dst_idle_pct = 0;
    int         err_count    = 0;
    int         codes_sent   = 0;
    int         chars_seen   = 0;
    int         escape_seqs  = 0;

    ps2_scancode_to_ascii dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic char_seq_t translate_code(input logic [ps2a_pkg::CODE_W-1:0] code);
        char_seq_t                   seq;
        logic [ps2a_pkg::KEY_W-1:0]  key;
        logic [ps2a_pkg::CHAR_W-1:0] base;
        logic [ps2a_pkg::CHAR_W-1:0] ch;
        logic                        letter;
        seq = '0;
        key = code[ps2a_pkg::KEY_W-1:0];
        if (code == ps2a_pkg::PREFIX_CODE)
        begin
            ext_pending = 1'b1;
        end
        else if (ext_pending)
        begin
            ext_pending = 1'b0;
            if (!code[ps2a_pkg::BREAK_BIT])
            begin
                seq.chars[0] = ps2a_pkg::CH_ESC;
                seq.chars[1] = ps2a_pkg::CH_LBRK;
                seq.count    = 3'd3;
                case (key)
                    ps2a_pkg::KEY_UP:    seq.chars[2] = ps2a_pkg::CH_A;
                    ps2a_pkg::KEY_DOWN:  seq.chars[2] = ps2a_pkg::CH_B;
                    ps2a_pkg::KEY_RIGHT: seq.chars[2] = ps2a_pkg::CH_C;
                    ps2a_pkg::KEY_LEFT:  seq.chars[2] = ps2a_pkg::CH_D;
                    ps2a_pkg::KEY_HOME:  seq.chars[2] = ps2a_pkg::CH_H;
                    ps2a_pkg::KEY_END:   seq.chars[2] = ps2a_pkg::CH_F;
                    ps2a_pkg::KEY_DEL:
                    begin
                        seq.chars[2] = ps2a_pkg::CH_3;
                        seq.chars[3] = ps2a_pkg::CH_TILDE;
                        seq.count    = 3'd4;
                    end
                    default:             seq = '0;
                endcase
            end
        end
        else if (code[ps2a_pkg::BREAK_BIT])
        begin
            if (key == ps2a_pkg::KEY_SHIFT_L || key == ps2a_pkg::KEY_SHIFT_R)
                shift_on = 1'b0;
            else if (key == ps2a_pkg::KEY_CTRL_L)
                ctrl_on = 1'b0;
        end
        else
        begin
            case (key) inside
                ps2a_pkg::KEY_SHIFT_L, ps2a_pkg::KEY_SHIFT_R: shift_on = 1'b1;
                ps2a_pkg::KEY_CTRL_L: ctrl_on = 1'b1;
                ps2a_pkg::KEY_CAPS:   caps_on = !caps_on;
                ps2a_pkg::KEY_ESC:
                begin
                    seq.chars[0] = ps2a_pkg::CH_ESC;
                    seq.count    = 3'd1;
                end
                ps2a_pkg::KEY_BKSP:
                begin
                    seq.chars[0] = ps2a_pkg::CH_BS;
                    seq.count    = 3'd1;
                end
                ps2a_pkg::KEY_RETURN:
                begin
                    seq.chars[0] = ps2a_pkg::CH_LF;
                    seq.count    = 3'd1;
                end
                ps2a_pkg::KEY_TAB:
                begin
                    seq.chars[0] = ps2a_pkg::CH_HT;
                    seq.count    = 3'd1;
                end
                default:
                begin
                    if (key < ps2a_pkg::TABLE_LEN)
                    begin
                        base   = LOWER_KEYS[key];
                        letter = (base >= ps2a_pkg::CH_LOW_A) && (base <= ps2a_pkg::CH_LOW_Z);
                        ch     = (shift_on ^ (caps_on && letter)) ? UPPER_KEYS[key] : base;
                        if (ch != 7'h00)
                        begin
                            if (!ctrl_on)
                            begin
                                seq.chars[0] = ch;
                                seq.count    = 3'd1;
                            end
                            else if (letter)
                            begin
                                seq.chars[0] = base - ps2a_pkg::CH_LOW_A + 7'd1;
                                seq.count    = 3'd1;
                            end
                        end
                    end
                end
            endcase
        end
        return seq;
    endfunction

    task automatic drive_code(input logic [ps2a_pkg::CODE_W-1:0] code, input logic typed,
                              input char_seq_t typed_seq);
        char_seq_t  seq;
        char_beat_t beat;
        int         k;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        do
            @(posedge clk);
        while (!s_axis_tready);
        seq = translate_code(code);
        if (typed)
            seq = typed_seq;
        for (k = 0; k < seq.count; k++)
        begin
            beat.char_code = seq.chars[k];
            beat.last_char = (k == seq.count - 1);
            char_q.push_back(beat);
        end
        codes_sent++;
        if (seq.count > 1)
            escape_seqs++;
    endtask

    task automatic drive_plain(input logic [ps2a_pkg::CODE_W-1:0] code);
        drive_code(code, 1'b0, '0);
    endtask

    task automatic random_keystroke();
        logic [ps2a_pkg::KEY_W-1:0] key;
        int                         pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            key = CURSOR_KEYS[$urandom_range(6)];
            drive_plain(ps2a_pkg::PREFIX_CODE);
            drive_plain({1'b0, key});
            if ($urandom_range(1))
            begin
                drive_plain(ps2a_pkg::PREFIX_CODE);
                drive_plain({1'b1, key});
            end
        end
        else if (pick < 30)
        begin
            case ($urandom_range(6))
                0: drive_plain({1'b0, ps2a_pkg::KEY_SHIFT_L});
                1: drive_plain({1'b0, ps2a_pkg::KEY_SHIFT_R});
                2: drive_plain({1'b1, ps2a_pkg::KEY_SHIFT_L});
                3: drive_plain({1'b1, ps2a_pkg::KEY_SHIFT_R});
                4: drive_plain({1'b0, ps2a_pkg::KEY_CTRL_L});
                5: drive_plain({1'b1, ps2a_pkg::KEY_CTRL_L});
                default: drive_plain({1'b0, ps2a_pkg::KEY_CAPS});
            endcase
        end
        else if (pick < 75)
        begin
            key = ps2a_pkg::KEY_W'($urandom_range(ps2a_pkg::TABLE_LEN - 1));
            drive_plain({1'b0, key});
            if ($urandom_range(1))
                drive_plain({1'b1, key});
        end
        else if (pick < 85)
        begin
            drive_plain(ps2a_pkg::PREFIX_CODE);
            drive_plain(ps2a_pkg::CODE_W'($urandom_range(255)));
        end
        else
        begin
            drive_plain(ps2a_pkg::CODE_W'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            chars_seen++;
            if (char_q.size() == 0)
            begin
                $error("char_code: expected none, got %h",
                       m_axis_tdata[ps2a_pkg::CHAR_W-1:0]);
                err_count++;
            end
            else
            begin
                want = char_q.pop_front();
                if (m_axis_tdata[ps2a_pkg::CHAR_W-1:0] !== want.char_code)
                begin
                    $error("char_code: expected %h, got %h", want.char_code,
                           m_axis_tdata[ps2a_pkg::CHAR_W-1:0]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last_char)
                begin
                    $error("last_char: expected %b, got %b", want.last_char, m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tdata[7] !== 1'b0)
                begin
                    $error("tdata fill: expected 0, got %b", m_axis_tdata[7]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int        phase;
        int        start_count;
        char_seq_t row_seq;
        shift_on    = 1'b0;
        ctrl_on     = 1'b0;
        caps_on     = 1'b0;
        ext_pending = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 10;
        dst_idle_pct = 47;
        for (int r = 0; r < N_ROWS; r++)
        begin
            row_seq.count = DIRECTED_ROWS[r].count;
            row_seq.chars = DIRECTED_ROWS[r].chars;
            drive_code(DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].typed, row_seq);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 47 : 0;
            dst_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 10 : 0;
            start_count  = codes_sent;
            while (codes_sent - start_count < PHASE_ITEMS)
                random_keystroke();
            if (phase == 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (char_q.size() != 0)
        begin
            $error("%0d characters never arrived", char_q.size());
            err_count++;
        end

        $display("Sent %0d scancodes; checked %0d characters including %0d escape sequences.",
                 codes_sent, chars_seen, escape_seqs);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/ps2a_pkg.sv
design/ps2a_decode.sv
design/ps2a_emit.sv
design/ps2_scancode_to_ascii.sv
tb/ps2_scancode_to_ascii_tb.sv
